// ----- rtl/poca_pkg.sv -----
// Shared types and constants for the pitot airspeed block with zero-offset calibration.
// Used by poca_regs and the top level; it has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package poca_pkg;

  // Sample and offset formats.
  localparam int AdcBits  = 24;
  localparam int OffFrac  = 8;
  localparam int OffW     = AdcBits + OffFrac;

  // Pressure conversion: uncal = (diff * 2500) >> 23.
  localparam logic [29:0] PaGain  = 30'd2500;
  localparam int          PaShift = AdcBits - 1 + OffFrac - 8;

  // Airspeed radicand: p * 512000 / 1293 = 396 * p - ceil(28 * p / 1293).
  // The ceiling is taken as floor((28 * p + 1292) * M >> 40), M = ceil(2^40 / 1293).
  localparam logic [29:0] RecipM     = 30'd850357021;
  localparam int          RecipShift = 40;
  localparam logic [10:0] RecipBias  = 11'd1292;

  // Saturation limits of the pressure result.
  localparam logic signed [23:0] PMax = 24'sh7FFFFF;
  localparam logic signed [23:0] PMin = -24'sh800000;

  // Configuration register indexes (byte address / 4).
  typedef enum logic [1:0] {
    REG_CALIB_SAMPLES   = 2'd0,
    REG_FILTER_KEEP     = 2'd1,
    REG_PRESSURE_SCALE  = 2'd2,
    REG_PRESSURE_OFFSET = 2'd3
  } reg_idx_t;

  // Configuration register values seen by the datapath.
  typedef struct packed {
    logic        [7:0]  calib_samples;
    logic        [8:0]  filter_keep;
    logic        [17:0] pressure_scale;
    logic signed [16:0] pressure_offset;
  } cfg_t;

  // Input word kind carried in tuser.
  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

endpackage

`default_nettype wire

// ----- rtl/poca_regs.sv -----
// APB-style configuration register file for the pitot airspeed block.
// Depends on poca_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module poca_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output poca_pkg::cfg_t     cfg
);

  poca_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = poca_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.calib_samples   <= 8'd20;
      cfg.filter_keep     <= 9'd154;
      cfg.pressure_scale  <= 18'd65536;
      cfg.pressure_offset <= 17'sd0;
    end else if (wr_en) begin
      unique case (idx)
        poca_pkg::REG_CALIB_SAMPLES:   cfg.calib_samples   <= pwdata[7:0];
        poca_pkg::REG_FILTER_KEEP:     cfg.filter_keep     <= pwdata[8:0];
        poca_pkg::REG_PRESSURE_SCALE:  cfg.pressure_scale  <= pwdata[17:0];
        poca_pkg::REG_PRESSURE_OFFSET: cfg.pressure_offset <= $signed(pwdata[16:0]);
        default: ;
      endcase
    end
  end

  // Read data; the offset register reads back sign-extended.
  always_comb begin
    unique case (idx)
      poca_pkg::REG_CALIB_SAMPLES:   prdata = {24'd0, cfg.calib_samples};
      poca_pkg::REG_FILTER_KEEP:     prdata = {23'd0, cfg.filter_keep};
      poca_pkg::REG_PRESSURE_SCALE:  prdata = {14'd0, cfg.pressure_scale};
      poca_pkg::REG_PRESSURE_OFFSET: prdata = 32'(cfg.pressure_offset);
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/poca_mul.sv -----
// Shared registered multiplier of the pitot airspeed block: signed 33 x unsigned 30 bits.
// No package dependency; operands come from the sequencer registers.
`timescale 1ns / 1ps
`default_nettype none

module poca_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic        [29:0] b,
  output logic signed      [62:0] prod
);

  // One product per cycle, registered at the output.
  always_ff @(posedge clk) begin
    prod <= a * $signed({1'b0, b});
  end

endmodule

`default_nettype wire

// ----- rtl/poca_isqrt.sv -----
// Bit-pair iterative integer square root of a 32-bit value.
// No package dependency; started by the sequencer in the top level.
`timescale 1ns / 1ps
`default_nettype none

module poca_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] value,
  output logic             done,
  output logic      [15:0] root_out
);

  logic        busy;
  logic [31:0] rem;
  logic [31:0] root;
  logic [31:0] bitr;
  logic [32:0] trial;

  assign trial    = {1'b0, root} + {1'b0, bitr};
  assign root_out = root[15:0];

  // One result bit per cycle, from the top bit pair down.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitr[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Remainder and root update.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      root <= 32'd0;
      bitr <= 32'h4000_0000;
    end else if (busy) begin
      if ({1'b0, rem} >= trial) begin
        rem  <= rem - trial[31:0];
        root <= (root >> 1) + bitr;
      end else begin
        root <= root >> 1;
      end
      bitr <= bitr >> 2;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pitot_offset_calibrated_airspeed.sv -----
// Top level of the pitot airspeed block: sequencer, offset state and output register.
// Depends on poca_pkg, poca_regs, poca_mul and poca_isqrt.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready with the raw 24-bit ADC code in s_tdata
//   and the kind in s_tuser (0 sample, 1 restart calibration). Results leave on
//   m_tvalid/m_tready: calibrated pressure in Pa Q8 and airspeed in m/s Q8.
//   Registers are written through the APB port; pready is always high.
// Sequence:
//   A restart word or the first calibration sample is taken in the idle state.
//   Other calibration samples make one pass through the shared multiplier. A
//   measurement sample makes three passes through the shared 33 x 30 multiplier,
//   then runs the bit-serial square root before reaching the output register; a
//   non-positive pressure skips the root.
//   s_tready is high only while the sequencer is idle.
// Reset:
//   Synchronous reset restores the register defaults, clears the offset, and
//   arms a 20-sample calibration; no result is sent until it is done.
// Stalls:
//   The output register holds a word until taken. The next input word is still
//   accepted; a finished result waits in the sequencer until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module pitot_offset_calibrated_airspeed (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [23:0] raw_sample
  input  wire logic        s_tuser,   // [0] op
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [23:0] pressure, [39:24] airspeed
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_CAL_MUL   = 12'b0000_0000_0010,
    S_CAL_WB    = 12'b0000_0000_0100,
    S_PA_MUL    = 12'b0000_0000_1000,
    S_PA_SCALE  = 12'b0000_0001_0000,
    S_SC_MUL    = 12'b0000_0010_0000,
    S_SC_SUM    = 12'b0000_0100_0000,
    S_RECIP_SET = 12'b0000_1000_0000,
    S_RECIP_MUL = 12'b0001_0000_0000,
    S_RAD       = 12'b0010_0000_0000,
    S_ROOT      = 12'b0100_0000_0000,
    S_DONE      = 12'b1000_0000_0000
  } state_t;

  state_t              state;
  poca_pkg::cfg_t      cfg;
  logic [31:0]         zero_offset;
  logic [7:0]          calib_remaining;
  logic [23:0]         raw;
  logic signed [32:0]  opa;
  logic [29:0]         opb;
  logic signed [62:0]  prod;
  logic signed [23:0]  p;
  logic [31:0]         p396;
  logic [15:0]         speed;
  logic [31:0]         rad;
  logic                sqrt_start;
  logic                sqrt_done;
  logic [15:0]         sqrt_root;

  logic                accept;
  logic [31:0]         rawq_in;
  logic [31:0]         diff_in;
  logic [8:0]          keep;
  logic signed [41:0]  blend_sum;
  logic signed [24:0]  p_sum;
  logic signed [23:0]  p_sat;
  logic [23:0]         p_mag;
  logic [27:0]         recip_x;
  logic [31:0]         p396_next;
  logic [17:0]         recip_q;

  poca_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  poca_mul u_mul (
    .clk  (clk),
    .a    (opa),
    .b    (opb),
    .prod (prod)
  );

  poca_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .value    (rad),
    .done     (sqrt_done),
    .root_out (sqrt_root)
  );

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid & s_tready;
  assign sqrt_start = (state == S_RAD);

  // Sample in offset format and its clamped distance above the offset.
  assign rawq_in = {s_tdata, 8'd0};
  assign diff_in = (rawq_in > zero_offset) ? (rawq_in - zero_offset) : 32'd0;
  assign keep    = cfg.filter_keep[8] ? 9'd256 : cfg.filter_keep;

  // Offset filter: (rawq << 8) + keep * (off - rawq) + 128, taken >> 8.
  assign blend_sum = $signed({2'b00, raw, 16'd0}) + $signed(prod[41:0]) + 42'sd128;

  // Scaled pressure plus offset, saturated to 24 bits signed.
  assign p_sum = $signed({2'b00, prod[38:16]}) + 25'(cfg.pressure_offset);
  always_comb begin
    if (!p_sum[24] && p_sum[23]) begin
      p_sat = poca_pkg::PMax;
    end else if (p_sum[24] && !p_sum[23]) begin
      p_sat = poca_pkg::PMin;
    end else begin
      p_sat = p_sum[23:0];
    end
  end

  // Radicand terms for a positive pressure: 396 * p and 28 * p + 1292.
  assign p_mag     = p;
  assign p396_next = ({8'd0, p_mag} << 8) + ({8'd0, p_mag} << 7)
                   + ({8'd0, p_mag} << 3) + ({8'd0, p_mag} << 2);
  assign recip_x   = ({4'd0, p_mag} << 5) - ({4'd0, p_mag} << 2)
                   + {17'd0, poca_pkg::RecipBias};
  assign recip_q   = prod[poca_pkg::RecipShift +: 18];

  // Radicand, ready for the root unit while the sequencer is in S_RAD.
  assign rad = p396 - {14'd0, recip_q};

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      zero_offset     <= 32'd0;
      calib_remaining <= 8'd20;
      m_tvalid        <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (poca_pkg::op_t'(s_tuser) == poca_pkg::OP_RESTART) begin
              calib_remaining <= cfg.calib_samples;
            end else if (calib_remaining != 8'd0) begin
              calib_remaining <= calib_remaining - 8'd1;
              if (calib_remaining == cfg.calib_samples) begin
                zero_offset <= rawq_in;
              end else begin
                state <= S_CAL_MUL;
              end
            end else begin
              state <= S_PA_MUL;
            end
          end
        end
        S_CAL_MUL:   state <= S_CAL_WB;
        S_CAL_WB: begin
          zero_offset <= blend_sum[39:8];
          state       <= S_IDLE;
        end
        S_PA_MUL:    state <= S_PA_SCALE;
        S_PA_SCALE:  state <= S_SC_MUL;
        S_SC_MUL:    state <= S_SC_SUM;
        S_SC_SUM:    state <= S_RECIP_SET;
        S_RECIP_SET: begin
          if (!p[23] && (p != 24'sd0)) begin
            state <= S_RECIP_MUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_RECIP_MUL: state <= S_RAD;
        S_RAD:       state <= S_ROOT;
        S_ROOT: begin
          if (sqrt_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; multiplier operands are loaded in the state before each multiply state.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        raw <= s_tdata;
        if (calib_remaining != 8'd0) begin
          opa <= $signed({1'b0, zero_offset}) - $signed({1'b0, rawq_in});
          opb <= {21'd0, keep};
        end else begin
          opa <= $signed({1'b0, diff_in});
          opb <= poca_pkg::PaGain;
        end
      end
      S_PA_SCALE: begin
        opa <= $signed({12'd0, prod[poca_pkg::PaShift +: 21]});
        opb <= {12'd0, cfg.pressure_scale};
      end
      S_SC_SUM: begin
        p <= p_sat;
      end
      S_RECIP_SET: begin
        opa   <= $signed({5'd0, recip_x});
        opb   <= poca_pkg::RecipM;
        p396  <= p396_next;
        speed <= 16'd0;
      end
      S_ROOT: begin
        if (sqrt_done) begin
          speed <= sqrt_root;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {speed, p};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
